// ===== hdl/lprr_pkg.sv =====
// Package for the length-prefixed record ring: command and status codes,
// and the structs that join the controller to the datapath.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lprr_pkg;

    // Request actions.
    localparam logic [1:0] ACT_PUSH  = 2'd0;
    localparam logic [1:0] ACT_POP   = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_PUSH_REJ = 2'd1;
    localparam logic [1:0] ST_BUSY     = 2'd2;
    localparam logic [1:0] ST_POP_FAIL = 2'd3;

    // Datapath command codes.
    typedef logic [3:0] t_cmd_code;
    localparam t_cmd_code CMD_NONE      = 4'd0;
    localparam t_cmd_code CMD_LATCH     = 4'd1;
    localparam t_cmd_code CMD_CLEAR     = 4'd2;
    localparam t_cmd_code CMD_PUSH_BYTE = 4'd3;
    localparam t_cmd_code CMD_WR_LO     = 4'd4;
    localparam t_cmd_code CMD_WR_HI     = 4'd5;
    localparam t_cmd_code CMD_FIRST     = 4'd6;
    localparam t_cmd_code CMD_RD_LEN0   = 4'd7;
    localparam t_cmd_code CMD_RD_LEN1   = 4'd8;
    localparam t_cmd_code CMD_RD_LEN2   = 4'd9;
    localparam t_cmd_code CMD_DROP      = 4'd10;
    localparam t_cmd_code CMD_POP_START = 4'd11;
    localparam t_cmd_code CMD_RD_BYTE   = 4'd12;
    localparam t_cmd_code CMD_POP_BYTE  = 4'd13;
    localparam t_cmd_code CMD_EMIT      = 4'd14;

    // One command per cycle, with an optional write of the result status.
    typedef struct packed {
        t_cmd_code  code;
        logic       st_we;
        logic [1:0] st;
    } t_cmd;

    // Datapath flags that steer the controller.
    typedef struct packed {
        logic [1:0] act;
        logic       push_busy;
        logic       pop_busy;
        logic       bad_len;
        logic       room_ok;
        logic       cant_drop;
        logic       corrupt;
        logic       pop_bad;
        logic       len_zero;
        logic       out_free;
    } t_dp_status;

endpackage

`default_nettype wire

// ===== hdl/lprr_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module lprr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== hdl/lprr_ctrl.sv =====
// Controller of the record ring: sequences each request through the
// datapath with one command per cycle. Depends on lprr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lprr_ctrl
    import lprr_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire t_dp_status i_dp,
    output t_cmd            o_cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECODE = 4'd1;
    localparam logic [3:0] S_CHECK  = 4'd2;
    localparam logic [3:0] S_RA0    = 4'd3;
    localparam logic [3:0] S_RA1    = 4'd4;
    localparam logic [3:0] S_RA2    = 4'd5;
    localparam logic [3:0] S_EVAL   = 4'd6;
    localparam logic [3:0] S_WLO    = 4'd7;
    localparam logic [3:0] S_WHI    = 4'd8;
    localparam logic [3:0] S_WFIRST = 4'd9;
    localparam logic [3:0] S_RB0    = 4'd10;
    localparam logic [3:0] S_RB1    = 4'd11;
    localparam logic [3:0] S_DONE   = 4'd12;

    logic [3:0] r_state;
    logic [3:0] n_state;

    // Next state and command.
    always_comb begin
        n_state     = r_state;
        o_cmd.code  = CMD_NONE;
        o_cmd.st_we = 1'b0;
        o_cmd.st    = ST_OK;
        o_ready     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.code = CMD_LATCH;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_DONE;
                unique case (i_dp.act)
                    ACT_PUSH: begin
                        if (i_dp.pop_busy) begin
                            o_cmd.st_we = 1'b1;
                            o_cmd.st    = ST_BUSY;
                        end else if (i_dp.push_busy) begin
                            o_cmd.code = CMD_PUSH_BYTE;
                        end else if (i_dp.bad_len) begin
                            o_cmd.st_we = 1'b1;
                            o_cmd.st    = ST_PUSH_REJ;
                        end else begin
                            n_state = S_CHECK;
                        end
                    end
                    ACT_POP: begin
                        if (i_dp.push_busy) begin
                            o_cmd.st_we = 1'b1;
                            o_cmd.st    = ST_BUSY;
                        end else if (i_dp.pop_busy) begin
                            n_state = S_RB0;
                        end else if (i_dp.cant_drop) begin
                            o_cmd.st_we = 1'b1;
                            o_cmd.st    = ST_POP_FAIL;
                        end else begin
                            n_state = S_RA0;
                        end
                    end
                    ACT_CLEAR: begin
                        o_cmd.code = CMD_CLEAR;
                    end
                    default: begin
                    end
                endcase
            end
            S_CHECK: begin
                if (i_dp.room_ok) begin
                    n_state = S_WLO;
                end else if (i_dp.cant_drop) begin
                    o_cmd.st_we = 1'b1;
                    o_cmd.st    = ST_PUSH_REJ;
                    n_state     = S_DONE;
                end else begin
                    n_state = S_RA0;
                end
            end
            S_RA0: begin
                o_cmd.code = CMD_RD_LEN0;
                n_state    = S_RA1;
            end
            S_RA1: begin
                o_cmd.code = CMD_RD_LEN1;
                n_state    = S_RA2;
            end
            S_RA2: begin
                o_cmd.code = CMD_RD_LEN2;
                n_state    = S_EVAL;
            end
            S_EVAL: begin
                if (i_dp.act == ACT_PUSH) begin
                    // A corrupt oldest length wipes the ring and rejects the push.
                    if (i_dp.corrupt) begin
                        o_cmd.code  = CMD_CLEAR;
                        o_cmd.st_we = 1'b1;
                        o_cmd.st    = ST_PUSH_REJ;
                        n_state     = S_DONE;
                    end else begin
                        o_cmd.code = CMD_DROP;
                        n_state    = S_CHECK;
                    end
                end else if (i_dp.pop_bad) begin
                    o_cmd.st_we = 1'b1;
                    o_cmd.st    = ST_POP_FAIL;
                    n_state     = S_DONE;
                end else begin
                    o_cmd.code = CMD_POP_START;
                    n_state    = i_dp.len_zero ? S_DONE : S_RB0;
                end
            end
            S_WLO: begin
                o_cmd.code = CMD_WR_LO;
                n_state    = S_WHI;
            end
            S_WHI: begin
                o_cmd.code = CMD_WR_HI;
                n_state    = S_WFIRST;
            end
            S_WFIRST: begin
                o_cmd.code = CMD_FIRST;
                n_state    = S_DONE;
            end
            S_RB0: begin
                o_cmd.code = CMD_RD_BYTE;
                n_state    = S_RB1;
            end
            S_RB1: begin
                o_cmd.code = CMD_POP_BYTE;
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (i_dp.out_free) begin
                    o_cmd.code = CMD_EMIT;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/lprr_dp.sv =====
// Datapath of the record ring: pointers, counters, progress state, the
// byte RAM and the output register. Depends on lprr_pkg and lprr_ram.
`timescale 1ns / 1ps
`default_nettype none

module lprr_dp
    import lprr_pkg::*;
#(
    parameter int CAPACITY = 4096
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cmd        i_cmd,
    output t_dp_status       o_dp,
    input  wire logic [1:0]  i_action,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic [15:0] i_record_length,
    input  wire logic [15:0] i_out_capacity,
    input  wire logic        i_ready,
    output logic             o_valid,
    output logic [1:0]       o_status,
    output logic [7:0]       o_out_byte,
    output logic             o_last_byte,
    output logic [12:0]      o_used_bytes,
    output logic [10:0]      o_record_count,
    output logic [31:0]      o_dropped_count,
    output logic             o_is_empty
);

    localparam int PW = $clog2(CAPACITY);
    localparam int UW = $clog2(CAPACITY + 1);
    localparam logic [UW:0] CAP_W = (UW + 1)'(CAPACITY);

    // Reduces a sum below twice the capacity to a ring address.
    function automatic logic [PW-1:0] f_wrap(input logic [UW:0] s);
        logic [UW:0] t;
        t = (s >= CAP_W) ? s - CAP_W : s;
        return t[PW-1:0];
    endfunction

    logic [PW-1:0] r_wp, r_rp, n_wp, n_rp;
    logic [UW-1:0] r_used, n_used, r_count, n_count;
    logic [UW-1:0] r_push_total, n_push_total, r_pop_total, n_pop_total;
    logic [31:0]   r_dropped, n_dropped;
    logic [15:0]   r_push_left, n_push_left, r_pop_left, n_pop_left;
    logic [1:0]    r_act;
    logic [7:0]    r_data;
    logic [15:0]   r_rlen, r_ocap, r_len, n_len;
    logic [1:0]    r_res_status, n_res_status;
    logic [7:0]    r_res_byte, n_res_byte;
    logic          r_res_last, n_res_last;
    logic          r_ovalid;

    logic [16:0]   w_need, w_total;
    logic          w_we;
    logic [7:0]    w_wdata;
    logic [PW-1:0] w_raddr;
    logic [7:0]    w_rdata;

    assign w_need  = 17'(r_rlen) + 17'd2;
    assign w_total = 17'(r_len) + 17'd2;

    // Flags for the controller.
    always_comb begin
        o_dp.act       = r_act;
        o_dp.push_busy = (r_push_left != 16'd0);
        o_dp.pop_busy  = (r_pop_left != 16'd0);
        o_dp.bad_len   = (r_rlen == 16'd0) || (w_need > 17'(CAPACITY));
        o_dp.room_ok   = (18'(r_used) + 18'(w_need)) <= 18'(CAPACITY);
        o_dp.cant_drop = (r_count == '0) || (r_used < UW'(2));
        o_dp.corrupt   = w_total > 17'(r_used);
        o_dp.pop_bad   = (r_len > r_ocap) || (w_total > 17'(r_used));
        o_dp.len_zero  = (r_len == 16'd0);
        o_dp.out_free  = !r_ovalid || i_ready;
    end

    // RAM ports.
    always_comb begin
        w_we    = 1'b0;
        w_wdata = r_data;
        w_raddr = r_rp;
        case (i_cmd.code) inside
            CMD_WR_LO: begin
                w_we    = 1'b1;
                w_wdata = r_rlen[7:0];
            end
            CMD_WR_HI: begin
                w_we    = 1'b1;
                w_wdata = r_rlen[15:8];
            end
            CMD_PUSH_BYTE, CMD_FIRST: begin
                w_we = 1'b1;
            end
            CMD_RD_LEN1: begin
                w_raddr = f_wrap((UW + 1)'(r_rp) + (UW + 1)'(1));
            end
            default: begin
            end
        endcase
    end

    lprr_ram #(
        .WIDTH (8),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_wp),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Next values of the ring state and the result.
    always_comb begin
        n_wp         = r_wp;
        n_rp         = r_rp;
        n_used       = r_used;
        n_count      = r_count;
        n_dropped    = r_dropped;
        n_push_left  = r_push_left;
        n_pop_left   = r_pop_left;
        n_push_total = r_push_total;
        n_pop_total  = r_pop_total;
        n_len        = r_len;
        n_res_status = i_cmd.st_we ? i_cmd.st : r_res_status;
        n_res_byte   = r_res_byte;
        n_res_last   = r_res_last;
        unique case (i_cmd.code) inside
            CMD_LATCH: begin
                n_res_status = ST_OK;
                n_res_byte   = 8'd0;
                n_res_last   = 1'b0;
            end
            CMD_CLEAR: begin
                n_wp         = '0;
                n_rp         = '0;
                n_used       = '0;
                n_count      = '0;
                n_dropped    = '0;
                n_push_left  = '0;
                n_pop_left   = '0;
                n_push_total = '0;
                n_pop_total  = '0;
            end
            CMD_WR_LO, CMD_WR_HI: begin
                n_wp = f_wrap((UW + 1)'(r_wp) + (UW + 1)'(1));
            end
            CMD_FIRST: begin
                n_wp         = f_wrap((UW + 1)'(r_wp) + (UW + 1)'(1));
                n_push_total = UW'(w_need);
                n_push_left  = r_rlen - 16'd1;
                if (r_rlen == 16'd1) begin
                    n_used     = r_used + UW'(w_need);
                    n_count    = r_count + UW'(1);
                    n_res_last = 1'b1;
                end
            end
            CMD_PUSH_BYTE: begin
                n_wp        = f_wrap((UW + 1)'(r_wp) + (UW + 1)'(1));
                n_push_left = r_push_left - 16'd1;
                if (r_push_left == 16'd1) begin
                    n_used     = r_used + r_push_total;
                    n_count    = r_count + UW'(1);
                    n_res_last = 1'b1;
                end
            end
            CMD_RD_LEN1: begin
                n_len = {r_len[15:8], w_rdata};
            end
            CMD_RD_LEN2: begin
                n_len = {w_rdata, r_len[7:0]};
            end
            CMD_DROP: begin
                n_rp      = f_wrap((UW + 1)'(r_rp) + (UW + 1)'(w_total));
                n_used    = r_used - UW'(w_total);
                n_count   = r_count - UW'(1);
                n_dropped = r_dropped + 32'd1;
            end
            CMD_POP_START: begin
                n_pop_total = UW'(w_total);
                n_rp        = f_wrap((UW + 1)'(r_rp) + (UW + 1)'(2));
                n_pop_left  = r_len;
                if (r_len == 16'd0) begin
                    n_used     = r_used - UW'(w_total);
                    n_count    = (r_count != '0) ? r_count - UW'(1) : r_count;
                    n_res_last = 1'b1;
                end
            end
            CMD_POP_BYTE: begin
                n_res_byte = w_rdata;
                n_rp       = f_wrap((UW + 1)'(r_rp) + (UW + 1)'(1));
                n_pop_left = r_pop_left - 16'd1;
                if (r_pop_left == 16'd1) begin
                    n_used     = (r_used >= r_pop_total) ? r_used - r_pop_total : '0;
                    n_count    = (r_count != '0) ? r_count - UW'(1) : r_count;
                    n_res_last = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // Control state with reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp         <= '0;
            r_rp         <= '0;
            r_used       <= '0;
            r_count      <= '0;
            r_dropped    <= '0;
            r_push_left  <= '0;
            r_pop_left   <= '0;
            r_push_total <= '0;
            r_pop_total  <= '0;
            r_ovalid     <= 1'b0;
        end else begin
            r_wp         <= n_wp;
            r_rp         <= n_rp;
            r_used       <= n_used;
            r_count      <= n_count;
            r_dropped    <= n_dropped;
            r_push_left  <= n_push_left;
            r_pop_left   <= n_pop_left;
            r_push_total <= n_push_total;
            r_pop_total  <= n_pop_total;
            if (i_cmd.code == CMD_EMIT) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Request fields, working result and output register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.code == CMD_LATCH) begin
            r_act  <= i_action;
            r_data <= i_data_byte;
            r_rlen <= i_record_length;
            r_ocap <= i_out_capacity;
        end
        r_len        <= n_len;
        r_res_status <= n_res_status;
        r_res_byte   <= n_res_byte;
        r_res_last   <= n_res_last;
        if (i_cmd.code == CMD_EMIT) begin
            o_status        <= r_res_status;
            o_out_byte      <= r_res_byte;
            o_last_byte     <= r_res_last;
            o_used_bytes    <= 13'(r_used);
            o_record_count  <= 11'(r_count);
            o_dropped_count <= r_dropped;
            o_is_empty      <= (r_count == '0);
        end
    end

    assign o_valid = r_ovalid;

endmodule

`default_nettype wire

// ===== hdl/length_prefixed_record_ring.sv =====
// Top level of the length-prefixed record ring.
// Usage:
//   The request channel (i_valid / o_ready) carries one action per request:
//   push one byte, pop one byte, or clear. Every request gives exactly one
//   result on the result channel (o_valid / i_ready) with status, popped
//   byte, last mark and the current counters.
//   A request is taken only while the serial controller is idle. Busy,
//   bad-length, clear and continuing-push requests and a pop with no record
//   go straight to the result; a continuing pop reads, then pops its byte; a
//   push with room writes both length bytes, then its first byte; a pop's
//   first byte follows a read of the oldest length prefix; a push that
//   cannot make room is rejected; each record dropped for room adds a read
//   of its prefix, one byte per cycle through the RAM's single read port.
//   The result sits in an output register, so a new request is taken while
//   the previous result still waits; a stalled receiver holds the block in
//   its final step until the register frees.
//   Reset (synchronous, active low) empties the ring, zeroes the counters
//   and drops any pending result; RAM contents are not cleared.
// Depends on lprr_pkg, lprr_ctrl, lprr_dp.
`timescale 1ns / 1ps
`default_nettype none

module length_prefixed_record_ring
    import lprr_pkg::*;
#(
    parameter int CAPACITY = 4096
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_action,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic [15:0] i_record_length,
    input  wire logic [15:0] i_out_capacity,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [1:0]       o_status,
    output logic [7:0]       o_out_byte,
    output logic             o_last_byte,
    output logic [12:0]      o_used_bytes,
    output logic [10:0]      o_record_count,
    output logic [31:0]      o_dropped_count,
    output logic             o_is_empty
);

    t_cmd       w_cmd;
    t_dp_status w_dp;

    lprr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_dp    (w_dp),
        .o_cmd   (w_cmd)
    );

    lprr_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_dp            (w_dp),
        .i_action        (i_action),
        .i_data_byte     (i_data_byte),
        .i_record_length (i_record_length),
        .i_out_capacity  (i_out_capacity),
        .i_ready         (i_ready),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_out_byte      (o_out_byte),
        .o_last_byte     (o_last_byte),
        .o_used_bytes    (o_used_bytes),
        .o_record_count  (o_record_count),
        .o_dropped_count (o_dropped_count),
        .o_is_empty      (o_is_empty)
    );

    // A push and a pop are never in progress at the same time.
    a_one_direction: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_dp.push_busy && w_dp.pop_busy))
        else $error("push and pop in progress together");

    // A completed record is only reported with an ok status.
    a_last_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_byte) |-> (o_status == ST_OK))
        else $error("last mark with a failing status");

    // A failing request never carries a popped byte.
    a_fail_no_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != ST_OK)) |-> (o_out_byte == 8'd0))
        else $error("byte returned with a failing status");

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// Self-checking testbench for the length-prefixed record ring.
// Drives push, pop and clear requests, predicts every result in-bench and compares.
// Depends on lprr_pkg and length_prefixed_record_ring.
`timescale 1ns / 1ps

module tb_top;
    import lprr_pkg::*;

    localparam int RING_BYTES  = 4096;
    localparam int CYCLE_LIMIT = 1500000;

    typedef struct {
        logic [1:0]  action;
        logic [7:0]  data;
        logic [15:0] rlen;
        logic [15:0] ocap;
        bit          drain;
    } ring_req_t;

    typedef struct {
        logic [1:0]  status;
        logic [7:0]  out_byte;
        logic        last;
        logic [12:0] used;
        logic [10:0] count;
        logic [31:0] dropped;
        logic        empty;
    } ring_result_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_action = ACT_PUSH;
    logic [7:0]  i_data_byte = 8'd0;
    logic [15:0] i_record_length = 16'd0;
    logic [15:0] i_out_capacity = 16'd0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [1:0]  o_status;
    logic [7:0]  o_out_byte;
    logic        o_last_byte;
    logic [12:0] o_used_bytes;
    logic [10:0] o_record_count;
    logic [31:0] o_dropped_count;
    logic        o_is_empty;

    length_prefixed_record_ring u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_action(i_action), .i_data_byte(i_data_byte),
        .i_record_length(i_record_length), .i_out_capacity(i_out_capacity),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_status(o_status), .o_out_byte(o_out_byte), .o_last_byte(o_last_byte),
        .o_used_bytes(o_used_bytes), .o_record_count(o_record_count),
        .o_dropped_count(o_dropped_count), .o_is_empty(o_is_empty)
    );

    always #4 i_clk = ~i_clk;

    ring_req_t    pending_q[$];
    ring_result_t expected_q[$];
    int           fail_cnt = 0;
    int           accepted_cnt = 0;
    int           cycle_cnt = 0;

    // Shadow copy of the ring state.
    bit [7:0]    ring_mem[RING_BYTES];
    int unsigned wr_ptr, rd_ptr, used_tot, rec_cnt, drop_tot;
    int unsigned push_rem, pop_rem, push_size, pop_size;

    function automatic int unsigned wrap(int unsigned p, int unsigned n);
        return (p + n) % RING_BYTES;
    endfunction

    function automatic void reset_ring();
        wr_ptr = 0; rd_ptr = 0; used_tot = 0; rec_cnt = 0; drop_tot = 0;
        push_rem = 0; pop_rem = 0; push_size = 0; pop_size = 0;
    endfunction

    function automatic int unsigned oldest_len();
        return {16'd0, ring_mem[wrap(rd_ptr, 1)], ring_mem[rd_ptr]};
    endfunction

    function automatic void put_byte(logic [7:0] v);
        ring_mem[wr_ptr] = v;
        wr_ptr = wrap(wr_ptr, 1);
    endfunction

    // Drops the oldest record; a corrupt length empties the whole ring.
    function automatic bit drop_oldest();
        int unsigned tot;
        if (rec_cnt == 0 || used_tot < 2) return 1'b0;
        tot = oldest_len() + 2;
        if (tot > used_tot) begin
            reset_ring();
            return 1'b0;
        end
        rd_ptr = wrap(rd_ptr, tot);
        used_tot -= tot;
        rec_cnt--;
        drop_tot++;
        return 1'b1;
    endfunction

    function automatic void finish_pop();
        used_tot = (used_tot >= pop_size) ? used_tot - pop_size : 0;
        if (rec_cnt != 0) rec_cnt--;
    endfunction

    // Applies one request to the shadow ring and returns its result.
    function automatic ring_result_t ring_apply(ring_req_t r);
        ring_result_t res;
        int unsigned  need, len;
        bit           ok;
        res.status = ST_OK;
        res.out_byte = 8'd0;
        res.last = 1'b0;
        case (r.action)
            ACT_PUSH: begin
                if (pop_rem != 0) begin
                    res.status = ST_BUSY;
                end else if (push_rem != 0) begin
                    put_byte(r.data);
                    push_rem--;
                    if (push_rem == 0) begin
                        used_tot += push_size; rec_cnt++; res.last = 1'b1;
                    end
                end else if (r.rlen == 0 || r.rlen + 2 > RING_BYTES) begin
                    res.status = ST_PUSH_REJ;
                end else begin
                    need = r.rlen + 2;
                    ok = 1'b1;
                    while (ok && RING_BYTES - used_tot < need) ok = drop_oldest();
                    if (!ok) begin
                        res.status = ST_PUSH_REJ;
                    end else begin
                        put_byte(r.rlen[7:0]);
                        put_byte(r.rlen[15:8]);
                        put_byte(r.data);
                        push_size = need;
                        push_rem = r.rlen - 1;
                        if (push_rem == 0) begin
                            used_tot += push_size; rec_cnt++; res.last = 1'b1;
                        end
                    end
                end
            end
            ACT_POP: begin
                if (push_rem != 0) begin
                    res.status = ST_BUSY;
                end else if (pop_rem != 0) begin
                    res.out_byte = ring_mem[rd_ptr];
                    rd_ptr = wrap(rd_ptr, 1);
                    pop_rem--;
                    if (pop_rem == 0) begin
                        finish_pop(); res.last = 1'b1;
                    end
                end else if (rec_cnt == 0 || used_tot < 2) begin
                    res.status = ST_POP_FAIL;
                end else begin
                    len = oldest_len();
                    if (len > r.ocap || len + 2 > used_tot) begin
                        res.status = ST_POP_FAIL;
                    end else begin
                        pop_size = len + 2;
                        rd_ptr = wrap(rd_ptr, 2);
                        if (len == 0) begin
                            finish_pop(); res.last = 1'b1;
                        end else begin
                            res.out_byte = ring_mem[rd_ptr];
                            rd_ptr = wrap(rd_ptr, 1);
                            pop_rem = len - 1;
                            if (pop_rem == 0) begin
                                finish_pop(); res.last = 1'b1;
                            end
                        end
                    end
                end
            end
            ACT_CLEAR: reset_ring();
            default: ;
        endcase
        res.used = used_tot[12:0];
        res.count = rec_cnt[10:0];
        res.dropped = drop_tot;
        res.empty = (rec_cnt == 0);
        return res;
    endfunction

    // Stimulus building blocks.
    task automatic add_req(logic [1:0] act, logic [15:0] rlen, logic [15:0] ocap, bit drain);
        ring_req_t r;
        r.action = act;
        r.data = 8'($urandom_range(0, 255));
        r.rlen = rlen;
        r.ocap = ocap;
        r.drain = drain;
        pending_q.push_back(r);
    endtask

    task automatic add_record(int len, int stop_at);
        for (int k = 0; k < len && k < stop_at; k++)
            add_req(ACT_PUSH, (k == 0) ? len[15:0] : 16'($urandom), 16'($urandom), 1'b0);
    endtask

    task automatic add_pops(int n);
        logic [15:0] cap;
        for (int k = 0; k < n; k++) begin
            cap = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 30)) : 16'($urandom);
            if ($urandom_range(0, 3) == 0) cap = 16'hFFFF;
            add_req(ACT_POP, 16'($urandom), cap, 1'b0);
        end
    endtask

    task automatic add_random_phase(int count);
        int goal, sel;
        goal = pending_q.size() + count;
        while (pending_q.size() < goal) begin
            sel = $urandom_range(0, 99);
            if (sel < 45) begin
                add_record(($urandom_range(0, 9) == 0) ? $urandom_range(25, 160)
                           : $urandom_range(1, 24), 1 << 20);
            end else if (sel < 80) begin
                add_pops($urandom_range(1, 14));
            end else if (sel < 86) begin
                // A record interrupted by the other direction, then finished.
                sel = $urandom_range(2, 12);
                add_record(sel, sel / 2);
                add_pops(1);
                for (int k = sel / 2; k < sel; k++)
                    add_req(ACT_PUSH, 16'($urandom), 16'($urandom), 1'b0);
            end else if (sel < 89) begin
                add_req(ACT_CLEAR, 16'($urandom), 16'($urandom), 1'b0);
            end else begin
                add_req(2'($urandom), 16'($urandom), 16'($urandom), 1'b0);
            end
        end
    endtask

    // Test sequence and end of run.
    initial begin
        // Directed requests covering the corner cases.
        add_req(ACT_POP, 16'd0, 16'hFFFF, 1'b0);
        add_req(ACT_PUSH, 16'd0, 16'd0, 1'b0);
        add_req(ACT_PUSH, 16'd4095, 16'd0, 1'b0);
        add_req(ACT_PUSH, 16'hFFFF, 16'd0, 1'b0);
        add_req(2'd3, 16'hFFFF, 16'hFFFF, 1'b0);
        add_record(1, 1);
        add_record(3, 1);
        add_pops(1);
        add_req(ACT_PUSH, 16'h1234, 16'd0, 1'b0);
        add_req(ACT_PUSH, 16'h0000, 16'd0, 1'b0);
        add_req(ACT_POP, 16'd0, 16'd0, 1'b0);
        add_req(ACT_POP, 16'd0, 16'd1, 1'b0);
        add_req(ACT_POP, 16'd0, 16'd3, 1'b0);
        add_req(ACT_PUSH, 16'd9, 16'd0, 1'b0);
        add_pops(2);
        add_record(5, 2);
        add_req(ACT_CLEAR, 16'd0, 16'd0, 1'b0);
        add_pops(1);
        add_record(2, 2);
        add_req(ACT_POP, 16'd0, 16'hFFFF, 1'b1);
        add_pops(1);
        // Random traffic; long records started after it drop held records to make room.
        add_random_phase(280);
        add_record(4094, 2);
        add_req(ACT_CLEAR, 16'd0, 16'd0, 1'b1);
        add_random_phase(280);
        add_record(4000, 2);
        add_req(ACT_CLEAR, 16'd0, 16'd0, 1'b0);
        add_random_phase(80);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (pending_q.size() == 0 && !i_valid && expected_q.size() == 0);
        repeat (40) @(posedge i_clk);
        if (expected_q.size() != 0) begin
            $error("results still expected: %0d", expected_q.size());
            fail_cnt++;
        end
        if (fail_cnt == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Request driver with prediction at acceptance.
    int send_gap = 0;
    always @(posedge i_clk) begin
        ring_req_t nxt;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                nxt.action = i_action;
                nxt.data = i_data_byte;
                nxt.rlen = i_record_length;
                nxt.ocap = i_out_capacity;
                nxt.drain = 1'b0;
                expected_q.push_back(ring_apply(nxt));
                accepted_cnt++;
            end
            if (!(i_valid && !o_ready)) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_valid <= 1'b0;
                end else if (pending_q.size() != 0 &&
                             (!pending_q[0].drain || expected_q.size() == 0)) begin
                    nxt = pending_q.pop_front();
                    i_valid <= 1'b1;
                    i_action <= nxt.action;
                    i_data_byte <= nxt.data;
                    i_record_length <= nxt.rlen;
                    i_out_capacity <= nxt.ocap;
                    if (pending_q.size() > 80 && $urandom_range(0, 9) == 0)
                        send_gap = $urandom_range(1, 18);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Result receiver: random stalls plus one long hold-off.
    int  recv_gap = 0;
    int  recv_hold = 0;
    bit  long_hold_done = 0;
    always @(posedge i_clk) begin
        if (!long_hold_done && accepted_cnt >= 300) begin
            long_hold_done = 1;
            recv_hold = 400;
        end
        if (recv_hold > 0) begin
            recv_hold--;
            i_ready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
            if (pending_q.size() > 80 && $urandom_range(0, 9) == 0)
                recv_gap = $urandom_range(1, 18);
        end
    end

    task automatic check_field(string name, longint unsigned want, longint unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_cnt++;
        end
    endtask

    // Result monitor.
    always @(posedge i_clk) begin
        ring_result_t want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_q.size() == 0) begin
                $error("result with no request outstanding");
                fail_cnt++;
            end else begin
                want = expected_q.pop_front();
                check_field("status", want.status, o_status);
                check_field("out_byte", want.out_byte, o_out_byte);
                check_field("last_byte", want.last, o_last_byte);
                check_field("used_bytes", want.used, o_used_bytes);
                check_field("record_count", want.count, o_record_count);
                check_field("dropped_count", want.dropped, o_dropped_count);
                check_field("is_empty", want.empty, o_is_empty);
            end
        end
    end

endmodule
